// ===== src/ptd_pkg.sv =====
// ptd_pkg: shared types and constants of the priority task dispatch unit
// used by preemptive_priority_task_dispatch_unit; no dependencies
package ptd_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NEST_DEPTH_DEF  = 8;

	localparam int REQ_W  = 2;
	localparam int TASK_W = 8;
	localparam int PRIO_W = 16;
	localparam int STAT_W = 2;
	localparam int ENT_W  = TASK_W + PRIO_W;

	localparam logic [PRIO_W-1:0] IDLE_LEVEL = 16'd9999;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD      = 2'd0,
		REQ_DISPATCH = 2'd1,
		REQ_COMPLETE = 2'd2,
		REQ_NOP      = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2,
		ST_NEST = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_CMP,
		S_ADD_WR,
		S_DSP_CMP,
		S_POP_CMP,
		S_FIN
	} state_t;

endpackage

// ===== src/preemptive_priority_task_dispatch_unit.sv =====
// preemptive_priority_task_dispatch_unit: sorted pending-task queue with a
// preemption stack of saved running levels
// depends on ptd_pkg and ptd_ram
//
// usage: requests arrive on the s_axis channel (tuser = request kind, tdata =
// task id and priority), one result per request leaves on m_axis (tuser =
// status, tdata = dispatched task, running level, pending count).
// the pending queue is a circular buffer in one ram, kept sorted; the saved
// levels sit in a second ram used as a stack.
// add walks the queue from the tail, shifting each entry with a larger
// priority up one place through the queue ram port, one entry a cycle, then
// writes the new task in behind; this walk is the longest request. dispatch
// and complete read the ram once before the result; add to a full queue,
// dispatch from an empty queue, complete with an empty stack and the unused
// code go straight to the result.
// one request is worked on at a time; s_axis_tready is high while idle and
// returns the cycle after the result is loaded.
// the result sits in an output register, so the next request is taken while
// the previous result still waits; a second result waits for the receiver.
// reset empties the queue and the stack and sets the running level to 9999;
// ram contents are not cleared (only entries already written are read).
module preemptive_priority_task_dispatch_unit #(
	parameter int QUEUE_DEPTH = ptd_pkg::QUEUE_DEPTH_DEF,
	parameter int NEST_DEPTH  = ptd_pkg::NEST_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int OUT_W = ((ptd_pkg::TASK_W + ptd_pkg::PRIO_W + CW + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// task_id [7:0], priority_req [23:8]
	input  logic [ptd_pkg::ENT_W-1:0]      s_axis_tdata,
	// req_type [1:0]
	input  logic [ptd_pkg::REQ_W-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// dispatched_task [7:0], running_priority [23:8], queue_count [23+CW:24], zero pad
	output logic [OUT_W-1:0]               m_axis_tdata,
	// status [1:0]
	output logic [ptd_pkg::STAT_W-1:0]     m_axis_tuser
);

	import ptd_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int NAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int NDW = $clog2(NEST_DEPTH + 1);

	state_t state_q, state_d;

	logic [QAW-1:0]    hd_q;
	logic [CW-1:0]     cnt_q;
	logic [NDW-1:0]    nd_q;
	logic [PRIO_W-1:0] level_q;
	logic [QAW-1:0]    k_q;
	logic [TASK_W-1:0] id_q;
	logic [PRIO_W-1:0] prio_q;
	status_t           stat_q;
	logic [TASK_W-1:0] started_q;

	logic              out_vld_q;
	logic [OUT_W-1:0]  out_data_q;
	status_t           out_stat_q;

	logic              q_we;
	logic [QAW-1:0]    q_waddr, q_raddr;
	logic [ENT_W-1:0]  q_wdata, q_rdata;
	logic              n_we;
	logic [NAW-1:0]    n_waddr, n_raddr;
	logic [PRIO_W-1:0] n_rdata;

	logic              accept;
	logic              out_free;
	req_t              req;
	logic              q_full, q_empty, n_full, n_empty;
	logic              greater;
	logic              dsp_ok;
	logic [QAW-1:0]    tail_k;
	logic [QAW-1:0]    k_next;

	// logical queue position to ram address, wrapping past the end
	function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] base,
			input logic [QAW-1:0] off);
		logic [QAW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (QAW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (QAW+1)'(QUEUE_DEPTH);
		end
		return sum[QAW-1:0];
	endfunction

	assign req      = req_t'(s_axis_tuser);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign q_full   = (cnt_q == CW'(QUEUE_DEPTH));
	assign q_empty  = (cnt_q == '0);
	assign n_full   = (nd_q == NDW'(NEST_DEPTH));
	assign n_empty  = (nd_q == '0);
	assign greater  = (q_rdata[PRIO_W-1:0] > prio_q);
	assign dsp_ok   = (level_q > q_rdata[PRIO_W-1:0]) && !n_full;
	assign tail_k   = QAW'(cnt_q - CW'(1));
	assign k_next   = k_q - QAW'(1);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_stat_q;

	ptd_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	ptd_ram #(.WIDTH(PRIO_W), .DEPTH(NEST_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (level_q),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req)
						REQ_ADD: begin
							if (q_full) state_d = S_FIN;
							else if (q_empty) state_d = S_ADD_WR;
							else state_d = S_ADD_CMP;
						end
						REQ_DISPATCH: state_d = q_empty ? S_FIN : S_DSP_CMP;
						REQ_COMPLETE: state_d = n_empty ? S_FIN : S_POP_CMP;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_ADD_CMP: begin
				if (!greater) state_d = S_FIN;
				else if (k_q == '0) state_d = S_ADD_WR;
			end
			S_ADD_WR:  state_d = S_FIN;
			S_DSP_CMP: state_d = S_FIN;
			S_POP_CMP: state_d = S_FIN;
			S_FIN:     if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		q_we    = 1'b0;
		q_waddr = phys(hd_q, k_q);
		q_wdata = {id_q, prio_q};
		q_raddr = phys(hd_q, k_next);
		n_we    = 1'b0;
		n_waddr = nd_q[NAW-1:0];
		n_raddr = NAW'(nd_q - NDW'(1));
		case (state_q)
			S_IDLE: begin
				q_raddr = (req == REQ_ADD) ? phys(hd_q, tail_k) : hd_q;
			end
			S_ADD_CMP: begin
				// shift a larger entry up one place, or drop the new task in behind it
				q_we    = 1'b1;
				q_waddr = phys(hd_q, k_q + QAW'(1));
				q_wdata = greater ? q_rdata : {id_q, prio_q};
			end
			S_ADD_WR:  q_we = 1'b1;
			S_DSP_CMP: n_we = dsp_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hd_q      <= '0;
			cnt_q     <= '0;
			nd_q      <= '0;
			level_q   <= IDLE_LEVEL;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
			case (state_q)
				S_ADD_CMP: if (!greater) cnt_q <= cnt_q + CW'(1);
				S_ADD_WR:  cnt_q <= cnt_q + CW'(1);
				S_DSP_CMP: begin
					if (dsp_ok) begin
						hd_q    <= (hd_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : hd_q + QAW'(1);
						cnt_q   <= cnt_q - CW'(1);
						nd_q    <= nd_q + NDW'(1);
						level_q <= q_rdata[PRIO_W-1:0];
					end
				end
				S_POP_CMP: begin
					nd_q    <= nd_q - NDW'(1);
					level_q <= n_rdata;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					id_q      <= s_axis_tdata[TASK_W-1:0];
					prio_q    <= s_axis_tdata[ENT_W-1:TASK_W];
					k_q       <= q_empty ? '0 : tail_k;
					started_q <= '0;
					case (req)
						REQ_ADD:      stat_q <= q_full ? ST_FULL : ST_DONE;
						REQ_DISPATCH: stat_q <= q_empty ? ST_NONE : ST_DONE;
						REQ_COMPLETE: stat_q <= n_empty ? ST_NEST : ST_DONE;
						default:      stat_q <= ST_DONE;
					endcase
				end
			end
			S_ADD_CMP: if (greater && k_q != '0) k_q <= k_next;
			S_DSP_CMP: begin
				if (level_q <= q_rdata[PRIO_W-1:0]) begin
					stat_q <= ST_NONE;
				end else if (n_full) begin
					stat_q <= ST_NEST;
				end else begin
					started_q <= q_rdata[ENT_W-1:PRIO_W];
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_stat_q <= stat_q;
					out_data_q <= OUT_W'({cnt_q, level_q, started_q});
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/ptd_ram.sv =====
// ptd_ram: generic single-write, single-read synchronous ram
// read data is registered; no dependencies
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
